// ===== hdl/gait_swing_phase_detector_core_assert.svh =====
// assertion macros shared by the gait swing phase detector modules
// no dependencies; included by the modules that carry checks
`ifndef GAIT_SWING_PHASE_DETECTOR_CORE_ASSERT_SVH
`define GAIT_SWING_PHASE_DETECTOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define GSPD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define GSPD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define GSPD_ASSERT(lbl, clk, rstn, prop, msg)
`define GSPD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== hdl/gspd_pkg.sv =====
// shared types and constants of the gait swing phase detector
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package gspd_pkg;

  localparam int unsigned TimeBits     = 32;
  localparam int unsigned CfgBits      = 16;
  localparam int unsigned PermilleBits = 10;
  localparam int unsigned ScaleBits    = TimeBits + PermilleBits;
  localparam int unsigned NumLanes     = 4;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QueuePtrBits = $clog2(QueueDepth);
  localparam int unsigned QueueCntBits = $clog2(QueueDepth + 1);
  localparam int unsigned InDataBits   = 40;
  localparam int unsigned OutDataBits  = 88;
  localparam int unsigned ApbAddrBits  = 3;
  localparam int unsigned ApbDataBits  = 32;
  localparam int unsigned IterBits     = $clog2(PermilleBits);

  localparam logic [PermilleBits-1:0] PermilleMax = PermilleBits'(1000);
  localparam logic [IterBits-1:0]     IterLast    = IterBits'(PermilleBits - 1);

  localparam logic [CfgBits-1:0] DebounceReset = CfgBits'(50);
  localparam logic [CfgBits-1:0] MinSwingReset = CfgBits'(200);

  // register index, taken from paddr word bit
  localparam logic RegDebounce = 1'b0;
  localparam logic RegMinSwing = 1'b1;

  // contact lanes
  localparam int unsigned LaneExoHeel    = 0;
  localparam int unsigned LaneExoToe     = 1;
  localparam int unsigned LaneContraHeel = 2;
  localparam int unsigned LaneContraToe  = 3;

  // work handed from the front to the back
  typedef struct packed {
    logic                started;
    logic                ended;
    logic                swinging;
    logic                div_en;
    logic [TimeBits-1:0] num;
    logic [TimeBits-1:0] den;
    logic [TimeBits-1:0] swing_len;
    logic [TimeBits-1:0] stance_len;
  } job_t;

endpackage

// ===== hdl/gait_swing_phase_detector_core.sv =====
// top level of the gait swing phase detector: config registers, front, queue, back
// depends on gspd_pkg, gspd_front, gspd_queue, gspd_back
//
//  port group    dir   payload
//  s_axis_*      in    now_ms, exo_heel, exo_toe, contra_heel, contra_toe
//  m_axis_*      out   start/end pulses, swinging, progress, last lengths; one transfer per input
//  apb           cfg   debounce_ms at 0x0, minimum swing length at 0x4
//
// the front takes a sample in the cycle it arrives while the two-entry queue has room
// the back takes a sample with no division straight to its result register and runs the ten
// restoring divider steps for one with a division; it pops no new sample until the last is out
// a stalled output register holds the back; the queue absorbs up to two samples
// reset clears debouncers, swing state and registers to their defaults
`timescale 1ns / 1ps

module gait_swing_phase_detector_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // [31:0] now_ms, [32] exo_heel, [33] exo_toe, [34] contra_heel,
  // [35] contra_toe, [39:36] zero
  input  logic [gspd_pkg::InDataBits-1:0]      s_axis_tdata,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [0] swing start pulse, [1] swing end pulse, [2] swinging, [12:3] swing_progress,
  // [22:13] stance_progress, [54:23] last_swing_len, [86:55] last_stance_len,
  // [87] zero
  output logic [gspd_pkg::OutDataBits-1:0]     m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [gspd_pkg::ApbAddrBits-1:0]     paddr,
  input  logic [gspd_pkg::ApbDataBits-1:0]     pwdata,
  output logic [gspd_pkg::ApbDataBits-1:0]     prdata,
  output logic                                 pready
);

  localparam int unsigned CB = gspd_pkg::CfgBits;

  logic [CB-1:0]   debounce_q, debounce_d;
  logic [CB-1:0]   min_swing_q, min_swing_d;
  logic            wr_en;
  logic            push, q_full, pop, q_valid;
  gspd_pkg::job_t  push_job, pop_job;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    debounce_d  = debounce_q;
    min_swing_d = min_swing_q;
    if (wr_en) begin
      case (paddr[2])
        gspd_pkg::RegDebounce: debounce_d  = pwdata[CB-1:0];
        gspd_pkg::RegMinSwing: min_swing_d = pwdata[CB-1:0];
        default: begin
          debounce_d = debounce_q;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      gspd_pkg::RegDebounce: prdata = {{(gspd_pkg::ApbDataBits - CB){1'b0}}, debounce_q};
      gspd_pkg::RegMinSwing: prdata = {{(gspd_pkg::ApbDataBits - CB){1'b0}}, min_swing_q};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= gspd_pkg::DebounceReset;
      min_swing_q <= gspd_pkg::MinSwingReset;
    end else begin
      debounce_q  <= debounce_d;
      min_swing_q <= min_swing_d;
    end
  end

  gspd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .now_i          (s_axis_tdata[gspd_pkg::TimeBits-1:0]),
    .raw_i          (s_axis_tdata[gspd_pkg::TimeBits +: gspd_pkg::NumLanes]),
    .debounce_ms_i  (debounce_q),
    .min_swing_i    (min_swing_q),
    .q_full_i       (q_full),
    .push_o         (push),
    .job_o          (push_job)
  );

  gspd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_job_o  (pop_job)
  );

  gspd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (pop_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== hdl/gspd_front.sv =====
// front end: contact debouncers and swing/stance state, one job per sample
// depends on gspd_pkg and the assertion header
`timescale 1ns / 1ps
`include "gait_swing_phase_detector_core_assert.svh"

module gspd_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [gspd_pkg::TimeBits-1:0]   now_i,
  input  logic [gspd_pkg::NumLanes-1:0]   raw_i,
  input  logic [gspd_pkg::CfgBits-1:0]    debounce_ms_i,
  input  logic [gspd_pkg::CfgBits-1:0]    min_swing_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output gspd_pkg::job_t                  job_o
);

  localparam int unsigned TB = gspd_pkg::TimeBits;
  localparam int unsigned NL = gspd_pkg::NumLanes;

  logic [NL-1:0]  started_q, started_d;
  logic [NL-1:0]  level_q, level_d;
  logic [NL-1:0]  pending_q, pending_d;
  logic [TB-1:0]  chg_q [NL];
  logic [TB-1:0]  chg_d [NL];
  logic [NL-1:0]  rise, fall;

  logic           in_swing_q, in_swing_d;
  logic [TB-1:0]  start_t_q, start_t_d;
  logic [TB-1:0]  prev_t_q, prev_t_d;
  logic [TB-1:0]  end_t_q, end_t_d;
  logic [TB-1:0]  swing_len_q, swing_len_d;
  logic [TB-1:0]  stance_len_q, stance_len_d;
  logic           start_v_q, start_v_d;
  logic           prev_v_q, prev_v_d;
  logic           end_v_q, end_v_d;

  logic           accept;
  logic [TB-1:0]  deb_ext, min_ext;
  logic [TB-1:0]  from_start, from_end, stance_old, stance_new;
  logic           start_req, end_req, gap_ok, started, ended, in1, pv1;
  logic [TB-1:0]  len;

  assign accept     = in_valid_i & ~q_full_i;
  assign in_ready_o = ~q_full_i;
  assign push_o     = accept;
  assign deb_ext    = {{(TB - gspd_pkg::CfgBits){1'b0}}, debounce_ms_i};
  assign min_ext    = {{(TB - gspd_pkg::CfgBits){1'b0}}, min_swing_i};

  // per-lane hold-time debounce
  always_comb begin
    logic [TB-1:0] ct;
    for (int k = 0; k < NL; k++) begin
      started_d[k] = started_q[k];
      level_d[k]   = level_q[k];
      pending_d[k] = pending_q[k];
      chg_d[k]     = chg_q[k];
      rise[k]      = 1'b0;
      fall[k]      = 1'b0;
      ct           = pending_q[k] ? chg_q[k] : now_i;
      if (!started_q[k]) begin
        started_d[k] = 1'b1;
        level_d[k]   = raw_i[k];
        pending_d[k] = 1'b0;
        chg_d[k]     = '0;
      end else if (raw_i[k] != level_q[k]) begin
        if ((now_i - ct) >= deb_ext) begin
          level_d[k]   = raw_i[k];
          pending_d[k] = 1'b0;
          chg_d[k]     = '0;
          rise[k]      = raw_i[k];
          fall[k]      = ~raw_i[k];
        end else begin
          pending_d[k] = 1'b1;
          chg_d[k]     = ct;
        end
      end else begin
        pending_d[k] = 1'b0;
        chg_d[k]     = '0;
      end
    end
  end

  // all time differences are taken from now_i and registered values only
  assign from_start = now_i - start_t_q;
  assign from_end   = now_i - end_t_q;
  assign stance_old = start_t_q - prev_t_q;
  assign stance_new = now_i - start_t_q;

  always_comb begin
    start_req = rise[gspd_pkg::LaneContraHeel] | fall[gspd_pkg::LaneExoToe];
    end_req   = fall[gspd_pkg::LaneContraToe] | rise[gspd_pkg::LaneExoHeel];
    gap_ok    = ~end_v_q | (from_end >= min_ext);
    started   = start_req & gap_ok & ~in_swing_q;
    in1       = in_swing_q | started;
    pv1       = started ? start_v_q : prev_v_q;
    len       = started ? '0 : from_start;
    ended     = end_req & in1 & (len >= min_ext);

    in_swing_d   = in1 & ~ended;
    start_t_d    = started ? now_i : start_t_q;
    prev_t_d     = started ? start_t_q : prev_t_q;
    start_v_d    = start_v_q | started;
    prev_v_d     = pv1;
    end_t_d      = ended ? now_i : end_t_q;
    end_v_d      = end_v_q | ended;
    swing_len_d  = ended ? len : swing_len_q;
    stance_len_d = stance_len_q;
    if (ended && pv1) begin
      stance_len_d = started ? stance_new : stance_old;
    end

    job_o.started    = started;
    job_o.ended      = ended;
    job_o.swinging   = in_swing_d;
    job_o.swing_len  = swing_len_d;
    job_o.stance_len = stance_len_d;
    if (in_swing_d) begin
      job_o.div_en = (swing_len_d != '0);
      job_o.num    = len;
      job_o.den    = swing_len_d;
    end else begin
      job_o.div_en = end_v_d & (stance_len_d != '0);
      job_o.num    = ended ? '0 : from_end;
      job_o.den    = stance_len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q    <= '0;
      level_q      <= '0;
      pending_q    <= '0;
      for (int k = 0; k < NL; k++) begin
        chg_q[k] <= '0;
      end
      in_swing_q   <= 1'b0;
      start_t_q    <= '0;
      prev_t_q     <= '0;
      end_t_q      <= '0;
      swing_len_q  <= '0;
      stance_len_q <= '0;
      start_v_q    <= 1'b0;
      prev_v_q     <= 1'b0;
      end_v_q      <= 1'b0;
    end else if (accept) begin
      started_q    <= started_d;
      level_q      <= level_d;
      pending_q    <= pending_d;
      for (int k = 0; k < NL; k++) begin
        chg_q[k] <= chg_d[k];
      end
      in_swing_q   <= in_swing_d;
      start_t_q    <= start_t_d;
      prev_t_q     <= prev_t_d;
      end_t_q      <= end_t_d;
      swing_len_q  <= swing_len_d;
      stance_len_q <= stance_len_d;
      start_v_q    <= start_v_d;
      prev_v_q     <= prev_v_d;
      end_v_q      <= end_v_d;
    end
  end

  `GSPD_ASSERT(a_both_needs_zero_min, clk_i, rst_ni, (push_o && job_o.started && job_o.ended) |-> (min_swing_i == '0), "start and end together with nonzero minimum")
  `GSPD_ASSERT(a_end_leaves_stance, clk_i, rst_ni, (push_o && job_o.ended) |-> !job_o.swinging, "swing end still reports swinging")
  `GSPD_ASSERT(a_swing_has_start, clk_i, rst_ni, in_swing_q |-> start_v_q, "in swing without a recorded start")

endmodule

// ===== hdl/gspd_queue.sv =====
// short job queue between the front and the back end
// depends on gspd_pkg
`timescale 1ns / 1ps

module gspd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gspd_pkg::job_t  push_job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output gspd_pkg::job_t  pop_job_o
);

  localparam int unsigned PB = gspd_pkg::QueuePtrBits;
  localparam int unsigned CB = gspd_pkg::QueueCntBits;

  gspd_pkg::job_t  slot_q [gspd_pkg::QueueDepth];
  logic [PB-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CB-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o    = (cnt_q == CB'(gspd_pkg::QueueDepth));
  assign valid_o   = (cnt_q != '0);
  assign pop_job_o = slot_q[rd_q];
  assign do_push   = push_i & ~full_o;
  assign do_pop    = pop_i & valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PB'(gspd_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PB'(gspd_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_job_i;
    end
  end

endmodule

// ===== hdl/gspd_back.sv =====
// back end: restoring divider for the progress value and the result register
// depends on gspd_pkg and the assertion header
`timescale 1ns / 1ps
`include "gait_swing_phase_detector_core_assert.svh"

module gspd_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_valid_i,
  input  gspd_pkg::job_t                       q_job_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [gspd_pkg::OutDataBits-1:0]     out_data_o
);

  localparam int unsigned TB = gspd_pkg::TimeBits;
  localparam int unsigned SB = gspd_pkg::ScaleBits;
  localparam int unsigned PB = gspd_pkg::PermilleBits;
  localparam int unsigned IB = gspd_pkg::IterBits;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_DONE = 3'b100
  } bk_state_e;

  bk_state_e       state_q, state_d;
  gspd_pkg::job_t  job_q, job_d;
  logic [SB-1:0]   rem_q, rem_d;
  logic [TB-1:0]   den_q, den_d;
  logic [PB-1:0]   quo_q, quo_d;
  logic [IB-1:0]   bit_q, bit_d;
  logic            ovld_q, ovld_d;
  logic [gspd_pkg::OutDataBits-1:0] odata_q, odata_d;

  logic [SB-1:0]   num_ext, scaled, trial;
  logic            load_out;
  logic [PB-1:0]   sp, st;

  // 1000 * num as 1024 - 16 - 8
  assign num_ext = {{(SB - TB){1'b0}}, q_job_i.num};
  assign scaled  = (num_ext << 10) - (num_ext << 4) - (num_ext << 3);
  assign trial   = {{(SB - TB){1'b0}}, den_q} << bit_q;

  assign load_out = (state_q == BK_DONE) & (~ovld_q | out_ready_i);
  assign pop_o    = (state_q == BK_IDLE) & q_valid_i;

  always_comb begin
    sp = job_q.swinging ? quo_q : '0;
    st = job_q.swinging ? '0 : quo_q;
  end

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    bit_d   = bit_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          job_d = q_job_i;
          rem_d = scaled;
          den_d = q_job_i.den;
          bit_d = gspd_pkg::IterLast;
          quo_d = '0;
          if (!q_job_i.div_en) begin
            state_d = BK_DONE;
          end else if (q_job_i.num >= q_job_i.den) begin
            quo_d   = gspd_pkg::PermilleMax;
            state_d = BK_DONE;
          end else begin
            state_d = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        if (rem_q >= trial) begin
          rem_d        = rem_q - trial;
          quo_d[bit_q] = 1'b1;
        end
        if (bit_q == '0) begin
          state_d = BK_DONE;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      BK_DONE: begin
        if (load_out) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    ovld_d  = ovld_q;
    odata_d = odata_q;
    if (load_out) begin
      ovld_d  = 1'b1;
      odata_d = {1'b0, job_q.stance_len, job_q.swing_len, st, sp,
                 job_q.swinging, job_q.ended, job_q.started};
    end else if (out_ready_i) begin
      ovld_d = 1'b0;
    end
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = odata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    quo_q   <= quo_d;
    bit_q   <= bit_d;
    odata_q <= odata_d;
  end

  `GSPD_ASSERT(a_state_onehot, clk_i, rst_ni, $onehot(state_q), "back state not one-hot")
  `GSPD_ASSERT(a_quo_in_range, clk_i, rst_ni, (state_q == BK_DONE) |-> (quo_q <= gspd_pkg::PermilleMax), "progress above 1000")
  `GSPD_ASSERT(a_load_after_div, clk_i, rst_ni, (state_q == BK_DIV && bit_q == '0) |=> (state_q == BK_DONE), "divider did not finish")

endmodule

// ===== test/tb_gait_swing_phase_detector_core.sv =====
// self-checking testbench for gait_swing_phase_detector_core: contact samples in,
// phase reports out, checked against a tracker that mirrors debounce and swing logic
// depends on gspd_pkg and the core; stands alone otherwise
`timescale 1ns / 1ps

module tb_gait_swing_phase_detector_core;

  localparam int unsigned CycleLimit  = 500_000;
  localparam int unsigned PhaseItems  = 182;
  localparam int unsigned NumPhases   = 7;
  localparam int unsigned DrainCycles = 40;
  localparam logic [31:0] WrapBase    = 32'hFFFF_FE00;

  localparam logic [gspd_pkg::ApbAddrBits-1:0] AddrDebounce = {gspd_pkg::RegDebounce, 2'b00};
  localparam logic [gspd_pkg::ApbAddrBits-1:0] AddrMinSwing = {gspd_pkg::RegMinSwing, 2'b00};

  typedef enum logic [1:0] {EdgeNone, EdgeRise, EdgeFall} contact_edge_e;
  typedef enum int unsigned {StageHeelStrike, StageFlat, StageHeelOff, StageSwing} foot_stage_e;

  // packed from the msb down, so the lowest field of tdata comes last
  typedef struct packed {
    logic [31:0] stance_len;
    logic [31:0] swing_len;
    logic [9:0]  stance_prog;
    logic [9:0]  swing_prog;
    logic        swinging;
    logic        ended;
    logic        started;
  } gait_report_t;

  class gait_phase_tracker;
    logic [15:0]  debounce_ms   = gspd_pkg::DebounceReset;
    logic [15:0]  min_swing_len = gspd_pkg::MinSwingReset;
    bit           deb_started [gspd_pkg::NumLanes];
    bit           deb_level   [gspd_pkg::NumLanes];
    bit           deb_pending [gspd_pkg::NumLanes];
    logic [31:0]  deb_since   [gspd_pkg::NumLanes];
    bit           swinging;
    bit           start_ok, prev_ok, end_ok;
    logic [31:0]  start_t      = '0;
    logic [31:0]  prev_start_t = '0;
    logic [31:0]  end_t        = '0;
    logic [31:0]  swing_len    = '0;
    logic [31:0]  stance_len   = '0;
    gait_report_t awaited_reports [$];
    int unsigned  errors;

    function void set_register(logic [gspd_pkg::ApbAddrBits-1:0] addr, logic [31:0] value);
      if (addr == AddrDebounce) begin
        debounce_ms = value[15:0];
      end else begin
        min_swing_len = value[15:0];
      end
    endfunction

    function logic [31:0] register_value(logic [gspd_pkg::ApbAddrBits-1:0] addr);
      return (addr == AddrDebounce) ? 32'(debounce_ms) : 32'(min_swing_len);
    endfunction

    function int awaited();
      return awaited_reports.size();
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function contact_edge_e debounce_lane(int unsigned lane, bit raw, logic [31:0] now);
      logic [31:0] held;
      if (!deb_started[lane]) begin
        deb_started[lane] = 1'b1;
        deb_level[lane]   = raw;
        deb_pending[lane] = 1'b0;
        deb_since[lane]   = '0;
        return EdgeNone;
      end
      if (raw != deb_level[lane]) begin
        if (!deb_pending[lane]) begin
          deb_pending[lane] = 1'b1;
          deb_since[lane]   = now;
        end
        held = now - deb_since[lane];
        if (held >= 32'(debounce_ms)) begin
          deb_level[lane]   = raw;
          deb_pending[lane] = 1'b0;
          deb_since[lane]   = '0;
          return raw ? EdgeRise : EdgeFall;
        end
        return EdgeNone;
      end
      deb_pending[lane] = 1'b0;
      deb_since[lane]   = '0;
      return EdgeNone;
    endfunction

    // tenths of a percent, truncated, saturated
    function logic [9:0] permille(logic [31:0] num, logic [31:0] den);
      logic [63:0] scaled;
      if (num >= den) return 10'd1000;
      scaled = 64'(num) * 64'd1000;
      return 10'(scaled / 64'(den));
    endfunction

    function void note_sample(logic [39:0] sample);
      logic [31:0]   now;
      logic [31:0]   span;
      contact_edge_e e_heel, e_toe, c_heel, c_toe;
      gait_report_t  rep;
      now    = sample[31:0];
      e_heel = debounce_lane(gspd_pkg::LaneExoHeel, sample[32 + gspd_pkg::LaneExoHeel], now);
      e_toe  = debounce_lane(gspd_pkg::LaneExoToe, sample[32 + gspd_pkg::LaneExoToe], now);
      c_heel = debounce_lane(gspd_pkg::LaneContraHeel,
                             sample[32 + gspd_pkg::LaneContraHeel], now);
      c_toe  = debounce_lane(gspd_pkg::LaneContraToe, sample[32 + gspd_pkg::LaneContraToe], now);
      rep = '0;

      if ((c_heel == EdgeRise || e_toe == EdgeFall) && !swinging &&
          (!end_ok || (now - end_t) >= 32'(min_swing_len))) begin
        swinging     = 1'b1;
        prev_start_t = start_t;
        prev_ok      = start_ok;
        start_t      = now;
        start_ok     = 1'b1;
        rep.started  = 1'b1;
      end

      if ((c_toe == EdgeFall || e_heel == EdgeRise) && swinging) begin
        span = now - start_t;
        if (span >= 32'(min_swing_len)) begin
          swinging  = 1'b0;
          end_t     = now;
          end_ok    = 1'b1;
          swing_len = span;
          if (prev_ok) stance_len = start_t - prev_start_t;
          rep.ended = 1'b1;
        end
      end

      if (swinging) begin
        if (swing_len != 0) rep.swing_prog = permille(now - start_t, swing_len);
      end else if (end_ok && stance_len != 0) begin
        rep.stance_prog = permille(now - end_t, stance_len);
      end
      rep.swinging   = swinging;
      rep.swing_len  = swing_len;
      rep.stance_len = stance_len;
      awaited_reports.push_back(rep);
    endfunction

    function void check_report(logic [86:0] raw);
      gait_report_t got;
      gait_report_t want;
      got = raw;
      if (awaited_reports.size() == 0) begin
        $error("result transfer with no sample awaiting it");
        errors++;
        return;
      end
      want = awaited_reports.pop_front();
      compare("swing_start_pulse", want.started, got.started);
      compare("swing_end_pulse", want.ended, got.ended);
      compare("swinging", want.swinging, got.swinging);
      compare("swing_progress", want.swing_prog, got.swing_prog);
      compare("stance_progress", want.stance_prog, got.stance_prog);
      compare("last_swing_len", want.swing_len, got.swing_len);
      compare("last_stance_len", want.stance_len, got.stance_len);
    endfunction
  endclass

  logic                                 clk_i         = 1'b0;
  logic                                 rst_ni        = 1'b0;
  logic [gspd_pkg::InDataBits-1:0]      s_axis_tdata  = '0;
  logic                                 s_axis_tvalid = 1'b0;
  logic                                 s_axis_tready;
  logic [gspd_pkg::OutDataBits-1:0]     m_axis_tdata;
  logic                                 m_axis_tvalid;
  logic                                 m_axis_tready = 1'b0;
  logic                                 psel          = 1'b0;
  logic                                 penable       = 1'b0;
  logic                                 pwrite        = 1'b0;
  logic [gspd_pkg::ApbAddrBits-1:0]     paddr         = '0;
  logic [gspd_pkg::ApbDataBits-1:0]     pwdata        = '0;
  logic [gspd_pkg::ApbDataBits-1:0]     prdata;
  logic                                 pready;

  gait_phase_tracker tracker = new;
  int unsigned       tx_idle_pct;
  int unsigned       rx_idle_pct;
  int unsigned       cycle_count;

  gait_swing_phase_detector_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_report(m_axis_tdata[86:0]);
  end

  function automatic logic [1:0] foot_contacts(foot_stage_e stage);  // {toe, heel}
    case (stage)
      StageHeelStrike: return 2'b01;
      StageFlat:       return 2'b11;
      StageHeelOff:    return 2'b10;
      default:         return 2'b00;
    endcase
  endfunction

  // contacts: {contra_toe, contra_heel, exo_toe, exo_heel}
  task automatic send_sample(input logic [31:0] now, input logic [3:0] contacts);
    logic [39:0] sample;
    sample = {4'b0000, contacts, now};
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_sample(sample);
  endtask

  task automatic drain_reports();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracker.awaited() != 0) @(posedge clk_i);
  endtask

  // write, then read back in the following transfer
  task automatic write_register(input logic [gspd_pkg::ApbAddrBits-1:0] addr,
                                input logic [15:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_register(addr, 32'(value));
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.compare("prdata", tracker.register_value(addr), prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // two legs walking half a cycle apart, with glitches and some random contacts
  task automatic run_gait_phase(input int unsigned count);
    logic [31:0] now;
    logic [3:0]  contacts;
    foot_stage_e exo_stage, con_stage;
    int unsigned exo_hold, con_hold, step_max, roll, lane;
    step_max  = int'(tracker.debounce_ms) / 2 + int'(tracker.min_swing_len) / 4 + 4;
    now       = $urandom_range(0, 1) ? 32'($urandom())
                                     : 32'hFFFF_FFFF - 32'($urandom_range(0, step_max * 40));
    exo_stage = foot_stage_e'($urandom_range(0, 3));
    con_stage = foot_stage_e'((exo_stage + 2) % 4);
    exo_hold  = $urandom_range(1, 12);
    con_hold  = $urandom_range(1, 12);
    repeat (count) begin
      contacts = {foot_contacts(con_stage), foot_contacts(exo_stage)};
      roll     = $urandom_range(0, 99);
      if (roll < 3) begin
        contacts = 4'($urandom());
      end else if (roll < 12) begin
        lane           = $urandom_range(0, 3);
        contacts[lane] = ~contacts[lane];
      end
      send_sample(now, contacts);
      exo_hold--;
      if (exo_hold == 0) begin
        exo_stage = foot_stage_e'((exo_stage + 1) % 4);
        exo_hold  = $urandom_range(1, 12);
      end
      con_hold--;
      if (con_hold == 0) begin
        con_stage = foot_stage_e'((con_stage + 1) % 4);
        con_hold  = $urandom_range(1, 12);
      end
      now = now + (($urandom_range(0, 99) == 0) ? 32'($urandom())
                                                : 32'($urandom_range(1, step_max)));
    end
  endtask

  initial begin
    logic [15:0] deb_set [NumPhases];
    logic [15:0] min_set [NumPhases];
    deb_set = '{16'd0, 16'd65535, 16'd10, 16'd50, 16'd65535, 16'd1, 16'($urandom())};
    min_set = '{16'd0, 16'd65535, 16'd100, 16'd200, 16'd0, 16'd65535, 16'($urandom())};
    tx_idle_pct = 16;
    rx_idle_pct = 56;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: first sample loads levels, glitch, start with no end yet,
    // short swing, end with no earlier start, start and end requested together, wrap of time
    send_sample(WrapBase,           4'b1011);
    send_sample(WrapBase + 32'd10,  4'b1111);
    send_sample(WrapBase + 32'd30,  4'b1011);
    send_sample(WrapBase + 32'd40,  4'b1111);
    send_sample(WrapBase + 32'd90,  4'b1111);
    send_sample(WrapBase + 32'd95,  4'b1100);
    send_sample(WrapBase + 32'd150, 4'b1100);
    send_sample(WrapBase + 32'd200, 4'b0100);
    send_sample(WrapBase + 32'd250, 4'b0100);
    send_sample(WrapBase + 32'd300, 4'b0101);
    send_sample(WrapBase + 32'd350, 4'b0101);
    send_sample(WrapBase + 32'd400, 4'b0111);
    send_sample(WrapBase + 32'd460, 4'b0111);
    send_sample(32'h0000_0000,      4'b0010);
    send_sample(32'h0000_0040,      4'b0010);
    send_sample(32'h0000_0050,      4'b0111);
    send_sample(32'h0000_0090,      4'b0111);
    send_sample(32'h0000_00A0,      4'b0100);
    send_sample(32'h0000_0100,      4'b0100);
    send_sample(32'h0000_0200,      4'b0101);
    send_sample(32'h0000_0240,      4'b0101);
    send_sample(32'h0000_0300,      4'b0101);
    send_sample(32'hFFFF_FFFF,      4'b1111);
    send_sample(32'h0000_0100,      4'b0000);
    drain_reports();

    for (int p = 0; p < NumPhases; p++) begin
      if (p < 2) begin
        tx_idle_pct = 16;
        rx_idle_pct = 56;
      end else if (p < 4) begin
        tx_idle_pct = 56;
        rx_idle_pct = 16;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_register(AddrDebounce, deb_set[p]);
      write_register(AddrMinSwing, min_set[p]);
      run_gait_phase(PhaseItems);
      drain_reports();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.awaited() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
